// ===== hw/rtl/tlik_pkg.sv =====
// Shared types and constants for the two-link planar inverse kinematics block.
// No dependencies; imported by tlik_sqrt, tlik_cordic and the top level.
package tlik_pkg;

    localparam int COORD_W   = 16;  // target coordinate, signed Q8.8
    localparam int LINK_W    = 15;  // link length, unsigned Q7.8
    localparam int ANGLE_W   = 16;  // joint angle, signed Q4.12
    localparam int RSQ_W     = 32;  // x^2 + y^2
    localparam int R_W       = 16;  // floor(sqrt(x^2 + y^2))
    localparam int LSQ_W     = 30;  // link length squared
    localparam int DEN_W     = 32;  // 2*a2*r and 2*a2*a4
    localparam int NUM_W     = 34;  // signed law-of-cosines numerator
    localparam int RAD_W     = 64;  // d^2 - n^2
    localparam int CW        = 44;  // CORDIC vector component
    localparam int M_W       = 41;  // magnitude field for normalization
    localparam int ZW        = 34;  // CORDIC angle accumulator, Q2.30
    localparam int AW        = 36;  // combined joint angle, Q2.30
    localparam int NORM_STEPS = 6;  // shifts of 32, 16, 8, 4, 2, 1
    localparam int ATAN_LEN  = 24;
    localparam int CFG_IDX_W = 1;
    localparam int ROUND_SH  = 18;  // Q2.30 -> Q4.12

    localparam logic [LINK_W-1:0] FIRST_LINK_RESET  = 15'd1536;
    localparam logic [LINK_W-1:0] SECOND_LINK_RESET = 15'd1408;

    localparam logic signed [AW-1:0] PI_Q30      = 36'sd3373259426;
    localparam logic signed [AW-1:0] HALF_PI_Q30 = 36'sd1686629713;

    // round(atan(2^-i) * 2^30)
    localparam logic [30:0] ATAN_TABLE [ATAN_LEN] = '{
        31'd843314857, 31'd497837829, 31'd263043836, 31'd133525159,
        31'd67021687,  31'd33543516,  31'd16775851,  31'd8388437,
        31'd4194283,   31'd2097149,   31'd1048576,   31'd524288,
        31'd262144,    31'd131072,    31'd65536,     31'd32768,
        31'd16384,     31'd8192,      31'd4096,      31'd2048,
        31'd1024,      31'd512,       31'd256,       31'd128
    };

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FIRST_LINK  = 1'b0,
        REG_SECOND_LINK = 1'b1
    } cfg_reg_t;

endpackage

// ===== hw/rtl/tlik_sqrt.sv =====
// Pipelined integer square root, one result bit per stage, several lanes.
// Depends on tlik_pkg (imported for house consistency of widths).
module tlik_sqrt
    import tlik_pkg::*;
#(
    parameter int W      = 32,
    parameter int LANES  = 1,
    parameter int SIDE_W = 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                in_valid,
    input  logic [W-1:0]        in_rad  [LANES],
    input  logic [SIDE_W-1:0]   in_side,
    output logic                out_valid,
    output logic [W/2-1:0]      out_root [LANES],
    output logic [SIDE_W-1:0]   out_side
);

    localparam int STG = W / 2;

    logic [W-1:0]      rem_reg  [STG][LANES];
    logic [STG-1:0]    root_bits [LANES];
    logic [W/2-1:0]    root_reg [STG][LANES];
    logic [SIDE_W-1:0] side_reg [STG];
    logic [STG-1:0]    valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[STG-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg[0] <= in_side;
            for (int k = 1; k < STG; k++) begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    for (genvar k = 0; k < STG; k++) begin : g_stage
        localparam int B = STG - 1 - k;
        for (genvar l = 0; l < LANES; l++) begin : g_lane
            logic [W-1:0]   prev_rem;
            logic [W/2-1:0] prev_root;
            logic [W:0]     trial;
            if (k == 0) begin : g_first
                assign prev_rem  = in_rad[l];
                assign prev_root = '0;
            end else begin : g_next
                assign prev_rem  = rem_reg[k-1][l];
                assign prev_root = root_reg[k-1][l];
            end
            // (root + 2^B)^2 - root^2
            assign trial = ((W+1)'(prev_root) << (B + 1)) + ((W+1)'(1) << (2 * B));
            always_ff @(posedge aclk) begin
                if (en) begin
                    if ({1'b0, prev_rem} >= trial) begin
                        rem_reg[k][l]  <= prev_rem - trial[W-1:0];
                        root_reg[k][l] <= prev_root | ((W/2)'(1) << B);
                    end else begin
                        rem_reg[k][l]  <= prev_rem;
                        root_reg[k][l] <= prev_root;
                    end
                end
            end
        end
    end

    for (genvar l = 0; l < LANES; l++) begin : g_out
        assign root_bits[l] = root_reg[STG-1][l][STG-1:0];
        assign out_root[l]  = root_bits[l];
    end

    assign out_valid = valid_reg[STG-1];
    assign out_side  = side_reg[STG-1];

endmodule

// ===== hw/rtl/tlik_cordic.sv =====
// Pipelined vectoring CORDIC with leading-zero normalization, several lanes.
// Depends on tlik_pkg for widths and the arctangent table.
module tlik_cordic
    import tlik_pkg::*;
#(
    parameter int STAGES = 16,
    parameter int LANES  = 3,
    parameter int SIDE_W = 5
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic signed [CW-1:0]  in_x [LANES],
    input  logic signed [CW-1:0]  in_y [LANES],
    input  logic [SIDE_W-1:0]     in_side,
    output logic                  out_valid,
    output logic signed [ZW-1:0]  out_angle [LANES],
    output logic [SIDE_W-1:0]     out_side
);

    localparam int TOT = 1 + NORM_STEPS + STAGES;

    logic signed [CW-1:0] x_reg [TOT][LANES];
    logic signed [CW-1:0] y_reg [TOT][LANES];
    logic [M_W-1:0]       m_reg [NORM_STEPS+1][LANES];
    logic signed [ZW-1:0] z_reg [STAGES][LANES];
    logic [SIDE_W-1:0]    side_reg [TOT];
    logic [TOT-1:0]       valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[TOT-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg[0] <= in_side;
            for (int k = 1; k < TOT; k++) begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    for (genvar l = 0; l < LANES; l++) begin : g_lane
        // magnitude = max(|y|, x)
        logic signed [CW-1:0] abs_y;
        assign abs_y = in_y[l][CW-1] ? -in_y[l] : in_y[l];
        always_ff @(posedge aclk) begin
            if (en) begin
                x_reg[0][l] <= in_x[l];
                y_reg[0][l] <= in_y[l];
                m_reg[0][l] <= (in_x[l] > abs_y) ? in_x[l][M_W-1:0] : abs_y[M_W-1:0];
            end
        end

        // shift until the magnitude has its top bit set
        for (genvar j = 0; j < NORM_STEPS; j++) begin : g_norm
            localparam int SH = 32 >> j;
            always_ff @(posedge aclk) begin
                if (en) begin
                    if (m_reg[j][l][M_W-1 -: SH] == '0) begin
                        x_reg[j+1][l] <= x_reg[j][l] <<< SH;
                        y_reg[j+1][l] <= y_reg[j][l] <<< SH;
                        m_reg[j+1][l] <= m_reg[j][l] << SH;
                    end else begin
                        x_reg[j+1][l] <= x_reg[j][l];
                        y_reg[j+1][l] <= y_reg[j][l];
                        m_reg[j+1][l] <= m_reg[j][l];
                    end
                end
            end
        end

        for (genvar i = 0; i < STAGES; i++) begin : g_rot
            localparam int P = NORM_STEPS + i;
            logic signed [ZW-1:0] z_prev;
            logic signed [ZW-1:0] step;
            logic signed [CW-1:0] xs;
            logic signed [CW-1:0] ys;
            if (i == 0) begin : g_z0
                assign z_prev = '0;
            end else begin : g_zn
                assign z_prev = z_reg[i-1][l];
            end
            assign step = $signed({{(ZW-31){1'b0}}, ATAN_TABLE[i]});
            assign xs   = x_reg[P][l] >>> i;
            assign ys   = y_reg[P][l] >>> i;
            always_ff @(posedge aclk) begin
                if (en) begin
                    if (!y_reg[P][l][CW-1]) begin
                        x_reg[P+1][l] <= x_reg[P][l] + ys;
                        y_reg[P+1][l] <= y_reg[P][l] - xs;
                        z_reg[i][l]   <= z_prev + step;
                    end else begin
                        x_reg[P+1][l] <= x_reg[P][l] - ys;
                        y_reg[P+1][l] <= y_reg[P][l] + xs;
                        z_reg[i][l]   <= z_prev - step;
                    end
                end
            end
        end

        assign out_angle[l] = z_reg[STAGES-1][l];
    end

    assign out_valid = valid_reg[TOT-1];
    assign out_side  = side_reg[TOT-1];

endmodule

// ===== hw/rtl/two_link_planar_inverse_kinematics.sv =====
// Pipeline from input word to result word, with CORDIC_STAGES at 16 by default:
// 2 squaring stages, 16 root stages, 4 law-of-cosines stages, 32 root stages,
// 7 + CORDIC_STAGES CORDIC stages, 1 combine stage and the output register.
// Throughput: one target word per cycle; every stage holds together when the
// output word is not taken. Synchronous active-low reset clears valid bits and
// loads the link lengths with 6.0 and 5.5.
module two_link_planar_inverse_kinematics
    import tlik_pkg::*;
#(
    parameter int CORDIC_STAGES = 16
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // configuration writes
    input  logic                        cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [LINK_W-1:0]           cfg_wdata,
    // target words
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic signed [COORD_W-1:0]   s_target_x,
    input  logic signed [COORD_W-1:0]   s_target_y,
    // joint angle words
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic signed [ANGLE_W-1:0]   m_shoulder_angle,
    output logic signed [ANGLE_W-1:0]   m_elbow_angle,
    output logic                        m_reachable
);

    localparam int SIDE1_W = 2 * COORD_W + RSQ_W;
    localparam int SIDE2_W = 2 * (DEN_W + 1) + 1 + 2 * COORD_W;
    localparam int SIDE3_W = 5;

    // Advance every stage whenever the output register is free or drained.
    logic m_valid_reg;
    logic adv;
    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = adv;

    //------------------------------------------------------------------
    // Configuration: link lengths and the products that depend only on them.
    //------------------------------------------------------------------
    logic [LINK_W-1:0] a2_reg, a4_reg;
    logic [LSQ_W-1:0]  a2sq_reg, a4sq_reg;
    logic [DEN_W-1:0]  d2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a2_reg <= FIRST_LINK_RESET;
            a4_reg <= SECOND_LINK_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_FIRST_LINK:  a2_reg <= cfg_wdata;
                REG_SECOND_LINK: a4_reg <= cfg_wdata;
            endcase
        end
    end

    // Track the link registers; the user must write only while idle (not enforced).
    always_ff @(posedge aclk) begin
        a2sq_reg <= a2_reg * a2_reg;
        a4sq_reg <= a4_reg * a4_reg;
        d2_reg   <= {(DEN_W-1)'(a2_reg * a4_reg), 1'b0};
    end

    //------------------------------------------------------------------
    // Stage A: square the coordinates.
    //------------------------------------------------------------------
    logic                      a_valid_reg;
    logic signed [COORD_W-1:0] a_x_reg, a_y_reg;
    logic [RSQ_W-2:0]          a_xx_reg, a_yy_reg;
    logic signed [RSQ_W-1:0]   xsq, ysq;

    assign xsq = s_target_x * s_target_x;
    assign ysq = s_target_y * s_target_y;

    always_ff @(posedge aclk) begin
        if (adv) begin
            a_x_reg  <= s_target_x;
            a_y_reg  <= s_target_y;
            a_xx_reg <= xsq[RSQ_W-2:0];
            a_yy_reg <= ysq[RSQ_W-2:0];
        end
    end

    //------------------------------------------------------------------
    // Stage B: r^2 = x^2 + y^2, exact.
    //------------------------------------------------------------------
    logic                      b_valid_reg;
    logic signed [COORD_W-1:0] b_x_reg, b_y_reg;
    logic [RSQ_W-1:0]          b_r2_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            b_x_reg  <= a_x_reg;
            b_y_reg  <= a_y_reg;
            b_r2_reg <= {1'b0, a_xx_reg} + {1'b0, a_yy_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else if (adv) begin
            a_valid_reg <= s_valid;
            b_valid_reg <= a_valid_reg;
        end
    end

    //------------------------------------------------------------------
    // Radius: r = floor(sqrt(r^2)).
    //------------------------------------------------------------------
    logic [RSQ_W-1:0]   rsq_in [1];
    logic [R_W-1:0]     r_out  [1];
    logic [SIDE1_W-1:0] side1_out;
    logic               r_valid;

    assign rsq_in[0] = b_r2_reg;

    tlik_sqrt #(
        .W      (RSQ_W),
        .LANES  (1),
        .SIDE_W (SIDE1_W)
    ) u_radius (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (b_valid_reg),
        .in_rad    (rsq_in),
        .in_side   ({b_x_reg, b_y_reg, b_r2_reg}),
        .out_valid (r_valid),
        .out_root  (r_out),
        .out_side  (side1_out)
    );

    logic signed [COORD_W-1:0] r_x, r_y;
    logic [RSQ_W-1:0]          r_r2;
    assign {r_x, r_y, r_r2} = side1_out;

    //------------------------------------------------------------------
    // Stage C: law-of-cosines numerators and the radius-dependent denominator.
    //------------------------------------------------------------------
    logic                      c_valid_reg;
    logic signed [COORD_W-1:0] c_x_reg, c_y_reg;
    logic signed [NUM_W-1:0]   c_n1_reg, c_n2_reg;
    logic [DEN_W-1:0]          c_d1_reg;
    logic                      c_rz_reg;

    logic signed [NUM_W-1:0] a2sq_s, a4sq_s, r2_s;
    assign a2sq_s = $signed({{(NUM_W-LSQ_W){1'b0}}, a2sq_reg});
    assign a4sq_s = $signed({{(NUM_W-LSQ_W){1'b0}}, a4sq_reg});
    assign r2_s   = $signed({{(NUM_W-RSQ_W){1'b0}}, r_r2});

    always_ff @(posedge aclk) begin
        if (adv) begin
            c_x_reg  <= r_x;
            c_y_reg  <= r_y;
            c_n1_reg <= a2sq_s + r2_s - a4sq_s;
            c_n2_reg <= a2sq_s + a4sq_s - r2_s;
            c_d1_reg <= {(DEN_W-1)'(a2_reg * r_out[0]), 1'b0};
            c_rz_reg <= (r_out[0] == '0);
        end
    end

    //------------------------------------------------------------------
    // Stage D: magnitudes and the reach test.
    //------------------------------------------------------------------
    logic                      d_valid_reg;
    logic signed [COORD_W-1:0] d_x_reg, d_y_reg;
    logic [DEN_W-1:0]          d_n1a_reg, d_n2a_reg, d_d1_reg;
    logic                      d_n1neg_reg, d_n2neg_reg, d_fail_reg;

    logic [NUM_W-1:0] n1_abs, n2_abs;
    logic             fail_now;
    assign n1_abs   = c_n1_reg[NUM_W-1] ? NUM_W'(-c_n1_reg) : NUM_W'(c_n1_reg);
    assign n2_abs   = c_n2_reg[NUM_W-1] ? NUM_W'(-c_n2_reg) : NUM_W'(c_n2_reg);
    // origin, a zero link or a cosine outside [-1, 1]
    assign fail_now = c_rz_reg || (c_d1_reg == '0) || (d2_reg == '0)
                   || (n1_abs > NUM_W'(c_d1_reg)) || (n2_abs > NUM_W'(d2_reg));

    always_ff @(posedge aclk) begin
        if (adv) begin
            d_x_reg     <= c_x_reg;
            d_y_reg     <= c_y_reg;
            d_n1a_reg   <= n1_abs[DEN_W-1:0];
            d_n2a_reg   <= n2_abs[DEN_W-1:0];
            d_n1neg_reg <= c_n1_reg[NUM_W-1];
            d_n2neg_reg <= c_n2_reg[NUM_W-1];
            d_d1_reg    <= c_d1_reg;
            d_fail_reg  <= fail_now;
        end
    end

    //------------------------------------------------------------------
    // Stage E: squares of numerators and denominators.
    //------------------------------------------------------------------
    logic                      e_valid_reg;
    logic signed [COORD_W-1:0] e_x_reg, e_y_reg;
    logic [DEN_W-1:0]          e_n1a_reg, e_n2a_reg;
    logic                      e_n1neg_reg, e_n2neg_reg, e_fail_reg;
    logic [RAD_W-1:0]          e_dd1_reg, e_nn1_reg, e_dd2_reg, e_nn2_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            e_x_reg     <= d_x_reg;
            e_y_reg     <= d_y_reg;
            e_n1a_reg   <= d_n1a_reg;
            e_n2a_reg   <= d_n2a_reg;
            e_n1neg_reg <= d_n1neg_reg;
            e_n2neg_reg <= d_n2neg_reg;
            e_fail_reg  <= d_fail_reg;
            e_dd1_reg   <= d_d1_reg * d_d1_reg;
            e_nn1_reg   <= d_n1a_reg * d_n1a_reg;
            e_dd2_reg   <= d2_reg * d2_reg;
            e_nn2_reg   <= d_n2a_reg * d_n2a_reg;
        end
    end

    //------------------------------------------------------------------
    // Stage F: d^2 - n^2, the square of the sine side.
    //------------------------------------------------------------------
    logic                      f_valid_reg;
    logic signed [COORD_W-1:0] f_x_reg, f_y_reg;
    logic [DEN_W-1:0]          f_n1a_reg, f_n2a_reg;
    logic                      f_n1neg_reg, f_n2neg_reg, f_fail_reg;
    logic [RAD_W-1:0]          f_rad_reg [2];

    always_ff @(posedge aclk) begin
        if (adv) begin
            f_x_reg      <= e_x_reg;
            f_y_reg      <= e_y_reg;
            f_n1a_reg    <= e_n1a_reg;
            f_n2a_reg    <= e_n2a_reg;
            f_n1neg_reg  <= e_n1neg_reg;
            f_n2neg_reg  <= e_n2neg_reg;
            f_fail_reg   <= e_fail_reg;
            f_rad_reg[0] <= e_dd1_reg - e_nn1_reg;
            f_rad_reg[1] <= e_dd2_reg - e_nn2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
            f_valid_reg <= 1'b0;
        end else if (adv) begin
            c_valid_reg <= r_valid;
            d_valid_reg <= c_valid_reg;
            e_valid_reg <= d_valid_reg;
            f_valid_reg <= e_valid_reg;
        end
    end

    //------------------------------------------------------------------
    // Sine sides: s = floor(sqrt(d^2 - n^2)) for both triangles.
    //------------------------------------------------------------------
    logic [DEN_W-1:0]   s_out [2];
    logic [SIDE2_W-1:0] side2_out;
    logic               s_valid_out;

    tlik_sqrt #(
        .W      (RAD_W),
        .LANES  (2),
        .SIDE_W (SIDE2_W)
    ) u_sine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (f_valid_reg),
        .in_rad    (f_rad_reg),
        .in_side   ({f_n1a_reg, f_n1neg_reg, f_n2a_reg, f_n2neg_reg, f_fail_reg,
                     f_x_reg, f_y_reg}),
        .out_valid (s_valid_out),
        .out_root  (s_out),
        .out_side  (side2_out)
    );

    logic [DEN_W-1:0]          s_n1a, s_n2a;
    logic                      s_n1neg, s_n2neg, s_fail;
    logic signed [COORD_W-1:0] s_x, s_y;
    assign {s_n1a, s_n1neg, s_n2a, s_n2neg, s_fail, s_x, s_y} = side2_out;

    //------------------------------------------------------------------
    // CORDIC vectors: lane 0 the target direction folded into the right
    // half plane, lanes 1 and 2 the two acos triangles. A negative cosine
    // side is turned a quarter turn so the x component stays non-negative.
    //------------------------------------------------------------------
    logic signed [CW-1:0]      cx [3];
    logic signed [CW-1:0]      cy [3];
    logic signed [COORD_W:0]   x_ext, y_ext, x_fold, y_fold;
    logic                      x_zero, y_pos;

    assign x_ext  = {s_x[COORD_W-1], s_x};
    assign y_ext  = {s_y[COORD_W-1], s_y};
    assign x_fold = s_x[COORD_W-1] ? -x_ext : x_ext;
    assign y_fold = s_x[COORD_W-1] ? -y_ext : y_ext;
    assign x_zero = (s_x == '0);
    assign y_pos  = !s_y[COORD_W-1] && (s_y != '0);

    assign cx[0] = CW'(x_fold);
    assign cy[0] = CW'(y_fold);
    assign cx[1] = $signed({{(CW-DEN_W){1'b0}}, s_n1neg ? s_out[0] : s_n1a});
    assign cy[1] = $signed({{(CW-DEN_W){1'b0}}, s_n1neg ? s_n1a : s_out[0]});
    assign cx[2] = $signed({{(CW-DEN_W){1'b0}}, s_n2neg ? s_out[1] : s_n2a});
    assign cy[2] = $signed({{(CW-DEN_W){1'b0}}, s_n2neg ? s_n2a : s_out[1]});

    logic signed [ZW-1:0]  z_out [3];
    logic [SIDE3_W-1:0]    side3_out;
    logic                  z_valid;

    tlik_cordic #(
        .STAGES (CORDIC_STAGES),
        .LANES  (3),
        .SIDE_W (SIDE3_W)
    ) u_cordic (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (s_valid_out),
        .in_x      (cx),
        .in_y      (cy),
        .in_side   ({x_zero, y_pos, s_n1neg, s_n2neg, s_fail}),
        .out_valid (z_valid),
        .out_angle (z_out),
        .out_side  (side3_out)
    );

    logic z_xzero, z_ypos, z_n1neg, z_n2neg, z_fail;
    assign {z_xzero, z_ypos, z_n1neg, z_n2neg, z_fail} = side3_out;

    //------------------------------------------------------------------
    // Stage G: atan with the vertical special case, acos with the quarter
    // turn added back for a negative cosine.
    //------------------------------------------------------------------
    logic                 g_valid_reg;
    logic signed [AW-1:0] g_at_reg, g_ac1_reg, g_ac2_reg;
    logic                 g_fail_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            if (z_xzero) begin
                g_at_reg <= z_ypos ? HALF_PI_Q30 : -HALF_PI_Q30;
            end else begin
                g_at_reg <= AW'(z_out[0]);
            end
            g_ac1_reg  <= z_n1neg ? HALF_PI_Q30 + AW'(z_out[1]) : AW'(z_out[1]);
            g_ac2_reg  <= z_n2neg ? HALF_PI_Q30 + AW'(z_out[2]) : AW'(z_out[2]);
            g_fail_reg <= z_fail;
        end
    end

    //------------------------------------------------------------------
    // Output register: joint angles rounded to Q4.12, zero when unreachable.
    //------------------------------------------------------------------
    logic signed [ANGLE_W-1:0] m_shoulder_reg, m_elbow_reg;
    logic                      m_reachable_reg;

    logic signed [AW-1:0] shoulder_q30, elbow_q30, shoulder_rnd, elbow_rnd;
    assign shoulder_q30 = g_at_reg - g_ac1_reg;
    assign elbow_q30    = PI_Q30 - g_ac2_reg;
    assign shoulder_rnd = shoulder_q30 + (AW'(1) <<< (ROUND_SH - 1));
    assign elbow_rnd    = elbow_q30 + (AW'(1) <<< (ROUND_SH - 1));

    always_ff @(posedge aclk) begin
        if (adv) begin
            if (g_fail_reg) begin
                m_shoulder_reg  <= '0;
                m_elbow_reg     <= '0;
                m_reachable_reg <= 1'b0;
            end else begin
                m_shoulder_reg  <= shoulder_rnd[ROUND_SH +: ANGLE_W];
                m_elbow_reg     <= elbow_rnd[ROUND_SH +: ANGLE_W];
                m_reachable_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            g_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            g_valid_reg <= z_valid;
            m_valid_reg <= g_valid_reg;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_shoulder_angle = m_shoulder_reg;
    assign m_elbow_angle    = m_elbow_reg;
    assign m_reachable      = m_reachable_reg;

    //------------------------------------------------------------------
    // Checks
    //------------------------------------------------------------------
    // An unreachable target always reports zero angles.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_reachable |-> m_shoulder_angle == '0 && m_elbow_angle == '0)
        else $error("unreachable word carries nonzero angles");

    // An accepted word enters the first stage.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> a_valid_reg)
        else $error("accepted word lost at stage A");

    // A stalled pipeline holds its first stage.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> $stable(a_x_reg) && $stable(a_y_reg) && $stable(a_valid_reg))
        else $error("stage A changed during stall");

endmodule

// ===== sim/tlik_angle_checker.sv =====
// Scoreboard for the two-link inverse kinematics block: predicts joint angles per target word.
// Depends on tlik_pkg; instantiated beside the block by tb_two_link_planar_inverse_kinematics.
`timescale 1ns / 100ps

module tlik_angle_checker
    import tlik_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [LINK_W-1:0]         cfg_wdata,
    input  logic                      s_valid,
    input  logic                      s_ready,
    input  logic signed [COORD_W-1:0] s_target_x,
    input  logic signed [COORD_W-1:0] s_target_y,
    input  logic                      m_valid,
    input  logic                      m_ready,
    input  logic signed [ANGLE_W-1:0] m_shoulder_angle,
    input  logic signed [ANGLE_W-1:0] m_elbow_angle,
    input  logic                      m_reachable,
    output int                        pending,
    output int                        failures
);

    localparam int NSTAGES = 16;
    localparam longint NORM_FLOOR = longint'(1) << 40;

    typedef struct packed {
        logic [ANGLE_W-1:0] shoulder;
        logic [ANGLE_W-1:0] elbow;
        logic               reach;
    } joint_word_t;

    joint_word_t       angles_due[$];
    logic [LINK_W-1:0] link_a, link_b;

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    // vectoring rotation; x >= 0, result in Q2.30
    function automatic longint vector_angle(longint x, longint y);
        longint m, z, xs, ys;
        m = (y < 0) ? -y : y;
        z = 0;
        if (x > m) m = x;
        if (m == 0) return 0;
        while (m < NORM_FLOOR) begin
            x *= 2; y *= 2; m *= 2;
        end
        for (int i = 0; i < NSTAGES; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x = x + ys; y = y - xs; z += longint'(ATAN_TABLE[i]);
            end else begin
                x = x - ys; y = y + xs; z -= longint'(ATAN_TABLE[i]);
            end
        end
        return z;
    endfunction

    function automatic longint arc_cosine(longint n, longint unsigned d);
        longint unsigned an;
        longint s;
        an = (n < 0) ? longint'(-n) : longint'(n);
        s = longint'(int_sqrt(d * d - an * an));
        if (n < 0) return longint'(HALF_PI_Q30) + vector_angle(s, -n);
        return vector_angle(n, s);
    endfunction

    function automatic logic [ANGLE_W-1:0] round_q12(longint v);
        longint t;
        t = (v + (longint'(1) << 17)) >>> ROUND_SH;
        return t[ANGLE_W-1:0];
    endfunction

    function automatic joint_word_t solve_joints(logic signed [COORD_W-1:0] tx,
                                                 logic signed [COORD_W-1:0] ty);
        longint x, y, a2, a4, r2, r, n1, n2, d1, d2, at;
        joint_word_t w;
        x = tx; y = ty;
        a2 = link_a; a4 = link_b;
        r2 = x * x + y * y;
        r = longint'(int_sqrt(r2));
        n1 = a2 * a2 + r2 - a4 * a4;
        n2 = a2 * a2 + a4 * a4 - r2;
        d1 = 2 * a2 * r;
        d2 = 2 * a2 * a4;
        w = '0;
        if (r == 0 || d1 == 0 || d2 == 0) return w;
        if (n1 > d1 || -n1 > d1 || n2 > d2 || -n2 > d2) return w;
        if (x == 0) at = (y > 0) ? longint'(HALF_PI_Q30) : -longint'(HALF_PI_Q30);
        else if (x < 0) at = vector_angle(-x, -y);
        else at = vector_angle(x, y);
        w.shoulder = round_q12(at - arc_cosine(n1, d1));
        w.elbow = round_q12(longint'(PI_Q30) - arc_cosine(n2, d2));
        w.reach = 1'b1;
        return w;
    endfunction

    assign pending = angles_due.size();

    initial failures = 0;

    always @(posedge aclk) begin
        joint_word_t want;
        if (!aresetn) begin
            link_a <= FIRST_LINK_RESET;
            link_b <= SECOND_LINK_RESET;
            angles_due.delete();
        end else begin
            // predict with the lengths in force before this edge
            if (s_valid && s_ready) angles_due.push_back(solve_joints(s_target_x, s_target_y));
            if (cfg_wr_en) begin
                if (cfg_index == REG_FIRST_LINK) link_a <= cfg_wdata;
                else link_b <= cfg_wdata;
            end
            if (m_valid && m_ready) begin
                if (angles_due.size() == 0) begin
                    $display("%0t: unexpected result word shoulder=%0d elbow=%0d reach=%0b",
                             $time, m_shoulder_angle, m_elbow_angle, m_reachable);
                    failures++;
                end else begin
                    want = angles_due.pop_front();
                    if (m_shoulder_angle !== want.shoulder) begin
                        $display("%0t: shoulder expected %0d actual %0d", $time,
                                 $signed(want.shoulder), m_shoulder_angle);
                        failures++;
                    end
                    if (m_elbow_angle !== want.elbow) begin
                        $display("%0t: elbow expected %0d actual %0d", $time,
                                 $signed(want.elbow), m_elbow_angle);
                        failures++;
                    end
                    if (m_reachable !== want.reach) begin
                        $display("%0t: reachable expected %0b actual %0b", $time,
                                 want.reach, m_reachable);
                        failures++;
                    end
                end
            end
        end
    end

endmodule

// ===== sim/tb_two_link_planar_inverse_kinematics.sv =====
// Top of the testbench for two_link_planar_inverse_kinematics: clock, reset, stimulus, verdict.
// Depends on tlik_pkg, the block itself and tlik_angle_checker.
`timescale 1ns / 100ps

module tb_two_link_planar_inverse_kinematics;
    import tlik_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int DRAIN_CYCLES = 100;

    logic                      aclk = 1'b0;
    logic                      aresetn = 1'b0;
    logic                      cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]      cfg_index = REG_FIRST_LINK;
    logic [LINK_W-1:0]         cfg_wdata = '0;
    logic                      s_valid = 1'b0;
    logic                      s_ready;
    logic signed [COORD_W-1:0] s_target_x = '0;
    logic signed [COORD_W-1:0] s_target_y = '0;
    logic                      m_valid;
    logic                      m_ready = 1'b0;
    logic signed [ANGLE_W-1:0] m_shoulder_angle, m_elbow_angle;
    logic                      m_reachable;
    logic                      no_gaps = 1'b0;
    int                        pending, failures;
    int                        cycles = 0;
    int                        link_a = FIRST_LINK_RESET, link_b = SECOND_LINK_RESET;

    two_link_planar_inverse_kinematics dut (.*);

    tlik_angle_checker checker_i (.*);

    initial begin
        forever #1 aclk = ~aclk;
    end

    // timeout guard
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // result side: drop ready with a chance of one in ten unless in the no-gap stretch
    always @(posedge aclk) begin
        if (aresetn) m_ready <= no_gaps ? 1'b1 : ($urandom_range(0, 99) >= 10);
    end

    // present one target word and hold it until accepted
    task automatic send_target(int x, int y);
        s_valid <= 1'b1;
        s_target_x <= x[COORD_W-1:0];
        s_target_y <= y[COORD_W-1:0];
        @(negedge aclk);
        while (!s_ready) @(negedge aclk);
        @(posedge aclk);
    endtask

    task automatic maybe_idle();
        if (!no_gaps && $urandom_range(0, 99) < 10) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
    endtask

    // drain all outstanding words, then load both link lengths
    task automatic set_links(int a, int b);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_FIRST_LINK;
        cfg_wdata <= a[LINK_W-1:0];
        @(posedge aclk);
        cfg_index <= REG_SECOND_LINK;
        cfg_wdata <= b[LINK_W-1:0];
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        link_a = a;
        link_b = b;
    endtask

    // mostly targets inside the reach box, the rest anywhere in the field range
    task automatic random_targets(int count);
        int lim;
        for (int i = 0; i < count; i++) begin
            maybe_idle();
            lim = link_a + link_b;
            if (lim > 32767) lim = 32767;
            if (lim < 1) lim = 1;
            if ($urandom_range(0, 99) < 85)
                send_target(int'($urandom_range(0, 2 * lim)) - lim,
                            int'($urandom_range(0, 2 * lim)) - lim);
            else
                send_target(int'($urandom_range(0, 65535)) - 32768,
                            int'($urandom_range(0, 65535)) - 32768);
        end
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed targets with reset link lengths 6.0 and 5.5
        send_target(0, 0);             // origin
        send_target(32767, 32767);     // far corner, out of reach
        send_target(-32768, -32768);
        send_target(-32768, 32767);
        send_target(20, 0);            // inside the inner dead zone
        send_target(0, 800);           // vertical, upward
        send_target(0, -800);          // vertical, downward
        send_target(-700, 300);        // negative x
        send_target(-700, -300);
        send_target(1000, 1000);
        send_target(2000, 0);
        send_target(2944, 0);          // fully stretched
        send_target(2943, 1);
        send_target(128, 0);           // fully folded
        send_target(0, 2944);
        send_target(-2000, 1);
        send_target(1500, -1500);
        send_target(300, -2500);

        random_targets(80);

        // long stretch with no idling on either side
        no_gaps = 1'b1;
        random_targets(70);
        no_gaps = 1'b0;

        set_links(32767, 32767);       // longest links
        send_target(32767, 0);
        send_target(-32768, 0);
        send_target(0, -32768);
        random_targets(60);

        set_links(1, 1);               // shortest nonzero links
        send_target(2, 0);
        send_target(1, 1);
        send_target(0, -1);
        random_targets(50);

        set_links(0, 1408);            // zero link length
        random_targets(30);
        set_links(1536, 0);
        random_targets(30);

        for (int p = 0; p < 3; p++) begin
            set_links($urandom_range(1, 4000), $urandom_range(1, 4000));
            random_targets(40);
        end

        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (failures == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/tlik_pkg.sv
hw/rtl/tlik_sqrt.sv
hw/rtl/tlik_cordic.sv
hw/rtl/two_link_planar_inverse_kinematics.sv
sim/tlik_angle_checker.sv
sim/tb_two_link_planar_inverse_kinematics.sv
